// ===== hdl/seven_segment_pair_frame_formatter_core_defines.svh =====
// ----------------------------------------------------------------------------
// Seven-segment pair frame formatter: assertion macros
// Shared property wrappers, clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SEVEN_SEGMENT_PAIR_FRAME_FORMATTER_CORE_DEFINES_SVH
`define SEVEN_SEGMENT_PAIR_FRAME_FORMATTER_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define SSPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SSPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/sspf_pkg.sv =====
// ----------------------------------------------------------------------------
// Seven-segment pair frame formatter package
// Types, register indexes, reset values and the segment table.
// ----------------------------------------------------------------------------
`default_nettype none

package sspf_pkg;

  localparam int DATA_W      = 8;
  localparam int FRAME_BYTES = 7;
  localparam int FRAME_W     = FRAME_BYTES * DATA_W;
  localparam int BEAT_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 40;

  // Register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_CONTROL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOOST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLANK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DASH    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_POINT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH   = 3'd5;

  // Register reset values
  localparam logic [DATA_W-1:0] RST_CONTROL = 8'd23;
  localparam logic [DATA_W-1:0] RST_BOOST   = 8'd32;
  localparam logic [DATA_W-1:0] RST_BLANK   = 8'd0;
  localparam logic [DATA_W-1:0] RST_DASH    = 8'd64;
  localparam logic [DATA_W-1:0] RST_POINT   = 8'd128;
  localparam logic [DATA_W-1:0] RST_FLASH   = 8'd50;

  // Item kinds carried on tuser
  localparam logic KIND_TICK   = 1'b0;
  localparam logic KIND_UPDATE = 1'b1;

  // Point digit codes
  localparam logic [2:0] PT_DIGIT1 = 3'd1;
  localparam logic [2:0] PT_DIGIT2 = 3'd2;
  localparam logic [2:0] PT_DIGIT3 = 3'd3;
  localparam logic [2:0] PT_DIGIT4 = 3'd4;

  localparam logic [DATA_W-1:0] SUBADDR  = 8'h00;
  localparam logic [DATA_W-1:0] TICK_MAX = 8'd255;

  // Display range of one pair
  localparam logic signed [DATA_W-1:0] VAL_MAX = 8'sd99;
  localparam logic signed [DATA_W-1:0] VAL_MIN = -8'sd9;

  // Divide by ten for 0..99: (x * 205) >> 11
  localparam logic [7:0] RECIP_10 = 8'd205;
  localparam int         RECIP_SH = 11;

  typedef struct packed {
    logic [DATA_W-1:0] control_word;
    logic [DATA_W-1:0] boost_mask;
    logic [DATA_W-1:0] blank_code;
    logic [DATA_W-1:0] dash_code;
    logic [DATA_W-1:0] point_mask;
    logic [DATA_W-1:0] flash_period;
  } cfg_t;

  // Per-pair override controls
  typedef struct packed {
    logic suppress;
    logic dash;
    logic flash_on;
    logic clear;
  } pair_ctl_t;

  // Update item held in the input register
  typedef struct packed {
    logic signed [DATA_W-1:0] high_value;
    logic signed [DATA_W-1:0] low_value;
    logic                     high_suppress_zero;
    logic                     low_suppress_zero;
    logic [1:0]               dash_pairs;
    logic [1:0]               flash_pairs;
    logic [2:0]               clear_pairs;
    logic                     boost_current;
    logic [2:0]               point_digit;
    logic [DATA_W-1:0]        slave_address;
    logic                     phase;
  } item_t;

  // Active-high segment code for a decimal digit (table is active low)
  function automatic logic [DATA_W-1:0] seg_digit(input logic [3:0] d);
    logic [DATA_W-1:0] raw;
    case (d)
      4'd0:    raw = 8'b11000000;
      4'd1:    raw = 8'b11111001;
      4'd2:    raw = 8'b10100100;
      4'd3:    raw = 8'b10110000;
      4'd4:    raw = 8'b10011001;
      4'd5:    raw = 8'b10010010;
      4'd6:    raw = 8'b10000010;
      4'd7:    raw = 8'b11111000;
      4'd8:    raw = 8'b10000000;
      4'd9:    raw = 8'b10010000;
      default: raw = 8'b11111111;
    endcase
    return ~raw;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/seven_segment_pair_frame_formatter_core.sv =====
// ----------------------------------------------------------------------------
// Seven-segment pair frame formatter core
// Formats two signed values into a 7-byte write frame for a four-digit
// LED driver, with flash timing driven by tick items.
// ----------------------------------------------------------------------------
// Tick items (tuser = 0) only advance the saturating tick counter; they are
// taken whenever the input is ready, which it is unless an update is waiting
// in the input register behind a frame that is still draining. An update item
// (tuser = 1) produces seven output beats: address, 0x00, control,
// digit1..digit4, tlast on the seventh. The first beat is presented after the
// update has passed the input register and then the frame buffer. The frame
// buffer gives one output beat per cycle while out_tready is high, and loads
// the next frame as the last beat is taken; a second update can wait in the
// input register while a frame drains. The flash counter and phase are
// updated when the item is accepted.
// Configuration writes are taken every cycle and should be made while idle.
`default_nettype none

module seven_segment_pair_frame_formatter_core (
  input  var logic                                clk,
  input  var logic                                rst_n,
  // Input stream
  input  var logic                                in_tvalid,
  output logic                                    in_tready,
  // [7:0] high_value, [15:8] low_value, [16] high_suppress_zero,
  // [17] low_suppress_zero, [19:18] dash_pairs, [21:20] flash_pairs,
  // [24:22] clear_pairs, [25] boost_current, [28:26] point_digit,
  // [36:29] slave_address, [39:37] zero
  input  var logic [sspf_pkg::IN_TDATA_W-1:0]     in_tdata,
  input  var logic                                in_tuser,    // [0] kind
  // Result stream
  output logic                                    out_tvalid,
  input  var logic                                out_tready,
  output logic [sspf_pkg::DATA_W-1:0]             out_tdata,   // [7:0] frame_byte
  output logic                                    out_tlast,   // last
  // Config write channel
  input  var logic                                cfg_valid,
  output logic                                    cfg_ready,
  input  var logic [sspf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  var logic [sspf_pkg::DATA_W-1:0]         cfg_data
);
  import sspf_pkg::*;

  cfg_t              cfg_r, cfg_nxt;
  logic [DATA_W-1:0] tick_r, tick_nxt;
  logic              phase_r, phase_nxt;
  item_t             item_r, item_nxt;
  logic              ivld_r, ivld_nxt;

  logic              in_acc;
  logic              load;
  logic              load_ok;
  item_t             in_item;
  pair_ctl_t         hctl, lctl;
  logic [DATA_W-1:0] ht, hu, lt, lu;
  logic              hclr, lclr;
  logic [DATA_W-1:0] ctrl_b, d1, d2, d3, d4;
  logic [FRAME_W-1:0] frame;

  assign cfg_ready = 1'b1;
  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = !ivld_r || load_ok;
  assign load      = ivld_r && load_ok;

  // Config registers
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        REG_CONTROL: cfg_nxt.control_word = cfg_data;
        REG_BOOST:   cfg_nxt.boost_mask   = cfg_data;
        REG_BLANK:   cfg_nxt.blank_code   = cfg_data;
        REG_DASH:    cfg_nxt.dash_code    = cfg_data;
        REG_POINT:   cfg_nxt.point_mask   = cfg_data;
        REG_FLASH:   cfg_nxt.flash_period = cfg_data;
        default:     cfg_nxt = cfg_r;
      endcase
    end
  end

  // Unpack the input beat
  always_comb begin
    in_item.high_value         = in_tdata[7:0];
    in_item.low_value          = in_tdata[15:8];
    in_item.high_suppress_zero = in_tdata[16];
    in_item.low_suppress_zero  = in_tdata[17];
    in_item.dash_pairs         = in_tdata[19:18];
    in_item.flash_pairs        = in_tdata[21:20];
    in_item.clear_pairs        = in_tdata[24:22];
    in_item.boost_current      = in_tdata[25];
    in_item.point_digit        = in_tdata[28:26];
    in_item.slave_address      = in_tdata[36:29];
    in_item.phase              = phase_nxt;
  end

  // Tick counter and flash phase, updated at accept
  always_comb begin
    tick_nxt  = tick_r;
    phase_nxt = phase_r;
    if (in_acc) begin
      if (in_tuser == KIND_TICK) begin
        if (tick_r != TICK_MAX) begin
          tick_nxt = tick_r + 1'b1;
        end
      end else if (tick_r >= cfg_r.flash_period) begin
        tick_nxt  = '0;
        phase_nxt = !phase_r;
      end
    end
  end

  // Input register holds one update until the frame buffer frees
  always_comb begin
    item_nxt = item_r;
    ivld_nxt = ivld_r;
    if (in_acc && (in_tuser == KIND_UPDATE)) begin
      item_nxt = in_item;
      ivld_nxt = 1'b1;
    end else if (load) begin
      ivld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r   <= '{control_word: RST_CONTROL, boost_mask: RST_BOOST,
                   blank_code: RST_BLANK, dash_code: RST_DASH,
                   point_mask: RST_POINT, flash_period: RST_FLASH};
      tick_r  <= '0;
      phase_r <= 1'b0;
      ivld_r  <= 1'b0;
    end else begin
      cfg_r   <= cfg_nxt;
      tick_r  <= tick_nxt;
      phase_r <= phase_nxt;
      ivld_r  <= ivld_nxt;
    end
    item_r <= item_nxt;
  end

  // Pair controls: clear bit2 covers both pairs
  assign hclr = item_r.clear_pairs[1] || item_r.clear_pairs[2];
  assign lclr = item_r.clear_pairs[0] || item_r.clear_pairs[2];

  always_comb begin
    hctl.suppress = item_r.high_suppress_zero;
    hctl.dash     = item_r.dash_pairs[1];
    hctl.flash_on = item_r.flash_pairs[1] && item_r.phase;
    hctl.clear    = hclr;
    lctl.suppress = item_r.low_suppress_zero;
    lctl.dash     = item_r.dash_pairs[0];
    lctl.flash_on = item_r.flash_pairs[0] && item_r.phase;
    lctl.clear    = lclr;
  end

  sspf_pair_enc u_enc_high (
    .value (item_r.high_value),
    .ctl   (hctl),
    .cfg   (cfg_r),
    .tens  (ht),
    .units (hu)
  );

  sspf_pair_enc u_enc_low (
    .value (item_r.low_value),
    .ctl   (lctl),
    .cfg   (cfg_r),
    .tens  (lt),
    .units (lu)
  );

  // Frame assembly, decimal point added after all overrides except on a cleared pair
  always_comb begin
    ctrl_b = cfg_r.control_word | (item_r.boost_current ? cfg_r.boost_mask : '0);
    d1 = lu | (((item_r.point_digit == PT_DIGIT1) && !lclr) ? cfg_r.point_mask : '0);
    d2 = lt | (((item_r.point_digit == PT_DIGIT2) && !lclr) ? cfg_r.point_mask : '0);
    d3 = hu | (((item_r.point_digit == PT_DIGIT3) && !hclr) ? cfg_r.point_mask : '0);
    d4 = ht | (((item_r.point_digit == PT_DIGIT4) && !hclr) ? cfg_r.point_mask : '0);
    frame = {d4, d3, d2, d1, ctrl_b, SUBADDR, item_r.slave_address};
  end

  sspf_frame_out u_frame_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .frame      (frame),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

// ===== hdl/sspf_pair_enc.sv =====
// ----------------------------------------------------------------------------
// Pair encoder
// Clamps one signed value to -9..99 and produces tens and units segment
// codes, then applies dash, flash blank and clear overrides.
// ----------------------------------------------------------------------------
`default_nettype none

module sspf_pair_enc (
  input  var logic signed [sspf_pkg::DATA_W-1:0] value,
  input  var sspf_pkg::pair_ctl_t                ctl,
  input  var sspf_pkg::cfg_t                     cfg,
  output logic [sspf_pkg::DATA_W-1:0]            tens,
  output logic [sspf_pkg::DATA_W-1:0]            units
);
  import sspf_pkg::*;

  logic signed [DATA_W-1:0] clamped;
  logic [6:0]               mag;
  logic [14:0]              prod;
  logic [3:0]               tens_d;
  logic [6:0]               tens_x10;
  logic [6:0]               units_full;
  logic [DATA_W-1:0]        neg_full;

  // Clamp to the displayable range
  always_comb begin
    if (value > VAL_MAX) begin
      clamped = VAL_MAX;
    end else if (value < VAL_MIN) begin
      clamped = VAL_MIN;
    end else begin
      clamped = value;
    end
  end

  // Split 0..99 into tens and units by reciprocal multiply
  assign mag        = clamped[6:0];
  assign prod       = {8'd0, mag} * {7'd0, RECIP_10};
  assign tens_d     = prod[14:RECIP_SH];
  assign tens_x10   = {tens_d, 3'b000} + {2'b00, tens_d, 1'b0};
  assign units_full = mag - tens_x10;
  assign neg_full   = SUBADDR - clamped;

  // Digit codes, then overrides in rising priority
  always_comb begin
    if (clamped[DATA_W-1]) begin
      tens  = cfg.dash_code;
      units = seg_digit(neg_full[3:0]);
    end else begin
      tens  = (ctl.suppress && (tens_d == 4'd0)) ? cfg.blank_code : seg_digit(tens_d);
      units = seg_digit(units_full[3:0]);
    end
    if (ctl.dash) begin
      tens  = cfg.dash_code;
      units = cfg.dash_code;
    end
    if (ctl.flash_on) begin
      tens  = cfg.blank_code;
      units = cfg.blank_code;
    end
    if (ctl.clear) begin
      tens  = cfg.blank_code;
      units = cfg.blank_code;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/sspf_frame_out.sv =====
// ----------------------------------------------------------------------------
// Frame output buffer
// Holds one assembled 7-byte frame and shifts it out one beat at a time,
// flagging the seventh beat with tlast.
// ----------------------------------------------------------------------------
`default_nettype none

module sspf_frame_out (
  input  var logic                             clk,
  input  var logic                             rst_n,
  input  var logic                             load,
  input  var logic [sspf_pkg::FRAME_W-1:0]     frame,
  output logic                                 load_ok,
  output logic                                 out_tvalid,
  input  var logic                             out_tready,
  output logic [sspf_pkg::DATA_W-1:0]          out_tdata,   // [7:0] frame_byte
  output logic                                 out_tlast
);
  import sspf_pkg::*;

  localparam logic [BEAT_W-1:0] LAST_BEAT = BEAT_W'(FRAME_BYTES - 1);

  logic [FRAME_W-1:0] frm_r,  frm_nxt;
  logic [BEAT_W-1:0]  beat_r, beat_nxt;
  logic               vld_r,  vld_nxt;
  logic               take;
  logic               is_last;

  assign is_last    = (beat_r == LAST_BEAT);
  assign take       = vld_r && out_tready;
  assign load_ok    = !vld_r || (take && is_last);
  assign out_tvalid = vld_r;
  assign out_tdata  = frm_r[DATA_W-1:0];
  assign out_tlast  = is_last;

  // Load a new frame or advance to the next byte
  always_comb begin
    frm_nxt  = frm_r;
    beat_nxt = beat_r;
    vld_nxt  = vld_r;
    if (load) begin
      frm_nxt  = frame;
      beat_nxt = '0;
      vld_nxt  = 1'b1;
    end else if (take) begin
      if (is_last) begin
        vld_nxt = 1'b0;
      end else begin
        frm_nxt  = {{DATA_W{1'b0}}, frm_r[FRAME_W-1:DATA_W]};
        beat_nxt = beat_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      beat_r <= '0;
    end else begin
      vld_r  <= vld_nxt;
      beat_r <= beat_nxt;
    end
    frm_r <= frm_nxt;
  end

endmodule

`default_nettype wire

// ===== hdl/sspf_checker.sv =====
// ----------------------------------------------------------------------------
// Frame formatter port checker
// Watches the result stream for frame length, subaddress byte and
// stall behavior; bound to the core.
// ----------------------------------------------------------------------------
`default_nettype none

`include "seven_segment_pair_frame_formatter_core_defines.svh"

module sspf_checker (
  input var logic       clk,
  input var logic       rst_n,
  input var logic       out_tvalid,
  input var logic       out_tready,
  input var logic [7:0] out_tdata,
  input var logic       out_tlast
);

  logic [2:0] beat_r;
  logic       take;

  assign take = out_tvalid && out_tready;

  // Position of the current beat within its frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beat_r <= 3'd0;
    end else if (take) begin
      beat_r <= out_tlast ? 3'd0 : beat_r + 3'd1;
    end
  end

  `SSPF_ASSERT_NOW(a_last_on_seventh, take && out_tlast, beat_r == 3'd6, "tlast off seventh beat")
  `SSPF_ASSERT_NOW(a_seventh_has_last, take && (beat_r == 3'd6), out_tlast, "frame without tlast")
  `SSPF_ASSERT_NOW(a_subaddr_zero, take && (beat_r == 3'd1), out_tdata == 8'h00, "bad subaddress")
  `SSPF_ASSERT_NEXT(a_stall_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled beat changed")

endmodule

bind seven_segment_pair_frame_formatter_core sspf_checker u_sspf_checker (.*);

`default_nettype wire
